[design/sm3hbl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sm3hbl_pkg
// Shared types, constants and functions for the SM3 bit-length hash core.
// ----------------------------------------------------------------------------
package sm3hbl_pkg;

    localparam logic [31:0] T_LOW  = 32'h79CC4519;
    localparam logic [31:0] T_HIGH = 32'h7A879D8A;

    localparam logic [31:0] IV [8] = '{
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    typedef enum logic [2:0] {
        WSEL_MSG,
        WSEL_PAD,
        WSEL_ZERO,
        WSEL_LHI,
        WSEL_LLO
    } word_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ZFILL,
        ST_LLO,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic      take;
        logic      append_en;
        word_sel_t word_sel;
        logic      load_work;
        logic      round_en;
        logic      fold;
        logic      emit_adv;
        logic      iv_load;
    } cmd_t;

    typedef struct packed {
        logic fill_last;
        logic fill_14;
        logic round_last;
        logic idx_last;
        logic in_full;
    } status_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] tmp;
        tmp = {x, x} << n;
        return tmp[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage
`default_nettype wire

[design/sm3_hash_bit_length.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sm3_hash_bit_length
// SM3 hash of a bit-length message streamed as 32-bit big-endian words.
// ----------------------------------------------------------------------------
// Non-final word: written into the block window; when it completes a 512-bit block
// the block is compressed (64 rounds on the single round unit, then one fold).
// Final word: padding appends one word at a time to fill the block, then 1 or 2
// compressions, then 8 digest beats, one per cycle when not stalled.
// Input: stalled while a 16-word block is compressed and while the digest is shown.
// Reset: chaining value loads the IV, counters and length clear; block is idle.
module sm3_hash_bit_length (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] msg_word,
    input  wire logic [5:0]  valid_bits,
    input  wire logic        final_word,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             digest_last
);

    sm3hbl_pkg::cmd_t    cmd;
    sm3hbl_pkg::status_t sts;

    sm3hbl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .final_word (final_word),
        .out_stall  (out_stall),
        .sts        (sts),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .cmd        (cmd)
    );

    sm3hbl_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .msg_word    (msg_word),
        .valid_bits  (valid_bits),
        .final_word  (final_word),
        .cmd         (cmd),
        .sts         (sts),
        .digest_word (digest_word),
        .word_index  (word_index)
    );

    assign digest_last = sts.idx_last;

    // Input is never taken while a digest is being shown.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && !in_stall))
        else $error("input open during digest output");

    // Digest output closes right after its last beat.
    a_emit_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && digest_last) |=> !out_valid)
        else $error("digest output continued past last beat");

    // Digest beats advance in order.
    a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !digest_last) |=>
            (out_valid && word_index == $past(word_index) + 3'd1))
        else $error("digest index skipped");

endmodule
`default_nettype wire

[design/sm3hbl_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sm3hbl_ctrl
// Sequencer: absorbs words, pads the final block, runs rounds, emits digest.
// ----------------------------------------------------------------------------
module sm3hbl_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               final_word,
    input  wire logic               out_stall,
    input  wire sm3hbl_pkg::status_t sts,
    output logic                    in_stall,
    output logic                    out_valid,
    output sm3hbl_pkg::cmd_t        cmd
);

    sm3hbl_pkg::state_t state_reg, state_next;
    sm3hbl_pkg::state_t ret_reg, ret_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sm3hbl_pkg::ST_IDLE;
            ret_reg   <= sm3hbl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            sm3hbl_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!final_word)
                    begin
                        if (sts.fill_last)
                        begin
                            state_next = sm3hbl_pkg::ST_ROUND;
                            ret_next   = sm3hbl_pkg::ST_IDLE;
                        end
                    end
                    else if (sts.in_full && sts.fill_last)
                    begin
                        state_next = sm3hbl_pkg::ST_ROUND;
                        ret_next   = sm3hbl_pkg::ST_PAD;
                    end
                    else
                    begin
                        state_next = sm3hbl_pkg::ST_PAD;
                    end
                end
            end
            sm3hbl_pkg::ST_PAD:
            begin
                if (sts.fill_last)
                begin
                    state_next = sm3hbl_pkg::ST_ROUND;
                    ret_next   = sm3hbl_pkg::ST_ZFILL;
                end
                else
                begin
                    state_next = sm3hbl_pkg::ST_ZFILL;
                end
            end
            sm3hbl_pkg::ST_ZFILL:
            begin
                if (sts.fill_14)
                begin
                    state_next = sm3hbl_pkg::ST_LLO;
                end
                else if (sts.fill_last)
                begin
                    state_next = sm3hbl_pkg::ST_ROUND;
                    ret_next   = sm3hbl_pkg::ST_ZFILL;
                end
            end
            sm3hbl_pkg::ST_LLO:
            begin
                state_next = sm3hbl_pkg::ST_ROUND;
                ret_next   = sm3hbl_pkg::ST_EMIT;
            end
            sm3hbl_pkg::ST_ROUND:
            begin
                if (sts.round_last)
                begin
                    state_next = sm3hbl_pkg::ST_FOLD;
                end
            end
            sm3hbl_pkg::ST_FOLD:
            begin
                state_next = ret_reg;
            end
            sm3hbl_pkg::ST_EMIT:
            begin
                if (!out_stall && sts.idx_last)
                begin
                    state_next = sm3hbl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sm3hbl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.word_sel = sm3hbl_pkg::WSEL_MSG;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        case (state_reg)
            sm3hbl_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.take = in_valid;
                if (in_valid && (!final_word || sts.in_full))
                begin
                    cmd.append_en = 1'b1;
                    cmd.load_work = sts.fill_last;
                end
            end
            sm3hbl_pkg::ST_PAD:
            begin
                cmd.append_en = 1'b1;
                cmd.word_sel  = sm3hbl_pkg::WSEL_PAD;
                cmd.load_work = sts.fill_last;
            end
            sm3hbl_pkg::ST_ZFILL:
            begin
                cmd.append_en = 1'b1;
                cmd.word_sel  = sts.fill_14 ? sm3hbl_pkg::WSEL_LHI : sm3hbl_pkg::WSEL_ZERO;
                cmd.load_work = sts.fill_last;
            end
            sm3hbl_pkg::ST_LLO:
            begin
                cmd.append_en = 1'b1;
                cmd.word_sel  = sm3hbl_pkg::WSEL_LLO;
                cmd.load_work = 1'b1;
            end
            sm3hbl_pkg::ST_ROUND:
            begin
                cmd.round_en = 1'b1;
            end
            sm3hbl_pkg::ST_FOLD:
            begin
                cmd.fold = 1'b1;
            end
            sm3hbl_pkg::ST_EMIT:
            begin
                out_valid    = 1'b1;
                cmd.emit_adv = !out_stall;
                cmd.iv_load  = !out_stall && sts.idx_last;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule
`default_nettype wire

[design/sm3hbl_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sm3hbl_dp
// Datapath: block window, length counter, round logic, chaining value.
// ----------------------------------------------------------------------------
module sm3hbl_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [31:0]         msg_word,
    input  wire logic [5:0]          valid_bits,
    input  wire logic                final_word,
    input  wire sm3hbl_pkg::cmd_t    cmd,
    output sm3hbl_pkg::status_t      sts,
    output logic [31:0]              digest_word,
    output logic [2:0]               word_index
);

    logic [31:0] win_reg [16];
    logic [31:0] work_reg [8];
    logic [31:0] chain_reg [8];
    logic [3:0]  fill_reg;
    logic [63:0] len_reg;
    logic [5:0]  round_reg;
    logic [2:0]  idx_reg;
    logic [31:0] lw_reg;
    logic [5:0]  lv_reg;

    logic [5:0]  v_sat;
    logic [31:0] pad_word;
    logic [31:0] app_word;
    logic [31:0] a12, tj, ss1, ss2, ff, gg, tt1, tt2, w_new;

    assign v_sat = (valid_bits >= 6'd32) ? 6'd32 : valid_bits;

    // Keep the leading valid bits, set the stop bit right after them.
    always_comb
    begin
        if (lv_reg[5])
        begin
            pad_word = 32'h80000000;
        end
        else
        begin
            pad_word = (lw_reg & ~(32'hFFFFFFFF >> lv_reg[4:0]))
                     | (32'h80000000 >> lv_reg[4:0]);
        end
    end

    always_comb
    begin
        case (cmd.word_sel)
            sm3hbl_pkg::WSEL_MSG:  app_word = msg_word;
            sm3hbl_pkg::WSEL_PAD:  app_word = pad_word;
            sm3hbl_pkg::WSEL_LHI:  app_word = len_reg[63:32];
            sm3hbl_pkg::WSEL_LLO:  app_word = len_reg[31:0];
            default:               app_word = 32'h0;
        endcase
    end

    always_comb
    begin
        a12 = sm3hbl_pkg::rotl(work_reg[0], 5'd12);
        tj  = sm3hbl_pkg::rotl((round_reg < 6'd16) ? sm3hbl_pkg::T_LOW : sm3hbl_pkg::T_HIGH,
                               round_reg[4:0]);
        ss1 = sm3hbl_pkg::rotl(a12 + work_reg[4] + tj, 5'd7);
        ss2 = ss1 ^ a12;
        if (round_reg < 6'd16)
        begin
            ff = work_reg[0] ^ work_reg[1] ^ work_reg[2];
            gg = work_reg[4] ^ work_reg[5] ^ work_reg[6];
        end
        else
        begin
            ff = (work_reg[0] & work_reg[1]) | (work_reg[0] & work_reg[2])
               | (work_reg[1] & work_reg[2]);
            gg = (work_reg[4] & work_reg[5]) | (~work_reg[4] & work_reg[6]);
        end
        tt1 = ff + work_reg[3] + ss2 + (win_reg[0] ^ win_reg[4]);
        tt2 = gg + work_reg[7] + ss1 + win_reg[0];
        w_new = sm3hbl_pkg::perm1(win_reg[0] ^ win_reg[7]
                                  ^ sm3hbl_pkg::rotl(win_reg[13], 5'd15))
              ^ sm3hbl_pkg::rotl(win_reg[3], 5'd7) ^ win_reg[10];
    end

    // Window shifts left: slot 15 takes the appended or expanded word.
    always_ff @(posedge clk)
    begin
        if (cmd.append_en || cmd.round_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= cmd.round_en ? w_new : app_word;
        end
        if (cmd.take && final_word)
        begin
            lw_reg <= msg_word;
            lv_reg <= v_sat;
        end
        if (cmd.load_work)
        begin
            for (int i = 0; i < 8; i++)
            begin
                work_reg[i] <= chain_reg[i];
            end
        end
        else if (cmd.round_en)
        begin
            work_reg[0] <= tt1;
            work_reg[1] <= work_reg[0];
            work_reg[2] <= sm3hbl_pkg::rotl(work_reg[1], 5'd9);
            work_reg[3] <= work_reg[2];
            work_reg[4] <= sm3hbl_pkg::perm0(tt2);
            work_reg[5] <= work_reg[4];
            work_reg[6] <= sm3hbl_pkg::rotl(work_reg[5], 5'd19);
            work_reg[7] <= work_reg[6];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            len_reg   <= '0;
            round_reg <= '0;
            idx_reg   <= '0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= sm3hbl_pkg::IV[i];
            end
        end
        else
        begin
            if (cmd.append_en)
            begin
                fill_reg <= fill_reg + 4'd1;
            end
            if (cmd.round_en)
            begin
                round_reg <= round_reg + 6'd1;
            end
            if (cmd.iv_load)
            begin
                len_reg <= '0;
            end
            else if (cmd.take)
            begin
                len_reg <= len_reg + {58'd0, (final_word ? v_sat : 6'd32)};
            end
            if (cmd.emit_adv)
            begin
                idx_reg <= idx_reg + 3'd1;
            end
            for (int i = 0; i < 8; i++)
            begin
                if (cmd.iv_load)
                begin
                    chain_reg[i] <= sm3hbl_pkg::IV[i];
                end
                else if (cmd.fold)
                begin
                    chain_reg[i] <= chain_reg[i] ^ work_reg[i];
                end
            end
        end
    end

    assign sts.fill_last  = (fill_reg == 4'd15);
    assign sts.fill_14    = (fill_reg == 4'd14);
    assign sts.round_last = (round_reg == 6'd63);
    assign sts.idx_last   = (idx_reg == 3'd7);
    assign sts.in_full    = (v_sat == 6'd32);

    assign digest_word = chain_reg[idx_reg];
    assign word_index  = idx_reg;

endmodule
`default_nettype wire

[dv/tb_sm3_hash_bit_length.sv]
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_sm3_hash_bit_length
// Streams messages of assorted bit lengths into the SM3 core and checks every
// digest beat against a cycle-free SM3 predictor, with random idling on both
// sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_sm3_hash_bit_length;

    typedef struct packed {
        logic [31:0] word;
        logic [5:0]  nbits;
        logic        fin;
    } msg_beat_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_beat_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] msg_word;
    logic [5:0]  valid_bits;
    logic        final_word;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;

    sm3_hash_bit_length u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .msg_word    (msg_word),
        .valid_bits  (valid_bits),
        .final_word  (final_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .digest_last (digest_last)
    );

    msg_beat_t    pending_beats[$];
    digest_beat_t expected_digests[$];

    logic [31:0] chain[8];
    logic [31:0] blk[16];
    int unsigned fill;
    logic [63:0] msg_bits;

    int  mismatches;
    int  beats_sent;
    int  digests_seen;
    bit  quiet_phase;
    bit  hold_off;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        n = n % 32;
        return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
    endfunction

    function automatic logic [31:0] p0f(input logic [31:0] x);
        return x ^ rol(x, 9) ^ rol(x, 17);
    endfunction

    function automatic logic [31:0] p1f(input logic [31:0] x);
        return x ^ rol(x, 15) ^ rol(x, 23);
    endfunction

    task automatic compress();
        logic [31:0] w[68];
        logic [31:0] r[8];
        logic [31:0] a12, tj, ss1, ss2, ff, gg, tt1, tt2;
        for (int i = 0; i < 16; i++) w[i] = blk[i];
        for (int i = 16; i < 68; i++)
            w[i] = p1f(w[i-16] ^ w[i-9] ^ rol(w[i-3], 15)) ^ rol(w[i-13], 7) ^ w[i-6];
        for (int i = 0; i < 8; i++) r[i] = chain[i];
        for (int j = 0; j < 64; j++)
        begin
            a12 = rol(r[0], 12);
            tj  = (j < 16) ? sm3hbl_pkg::T_LOW : sm3hbl_pkg::T_HIGH;
            ss1 = rol(a12 + r[4] + rol(tj, j), 7);
            ss2 = ss1 ^ a12;
            if (j < 16)
            begin
                ff = r[0] ^ r[1] ^ r[2];
                gg = r[4] ^ r[5] ^ r[6];
            end
            else
            begin
                ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
                gg = (r[4] & r[5]) | (~r[4] & r[6]);
            end
            tt1 = ff + r[3] + ss2 + (w[j] ^ w[j+4]);
            tt2 = gg + r[7] + ss1 + w[j];
            r[3] = r[2];
            r[2] = rol(r[1], 9);
            r[1] = r[0];
            r[0] = tt1;
            r[7] = r[6];
            r[6] = rol(r[5], 19);
            r[5] = r[4];
            r[4] = p0f(tt2);
        end
        for (int i = 0; i < 8; i++) chain[i] ^= r[i];
    endtask

    task automatic absorb_word(input logic [31:0] w);
        blk[fill] = w;
        fill = (fill + 1) % 16;
        if (fill == 0) compress();
    endtask

    task automatic predict_digest(input msg_beat_t b);
        int unsigned v;
        logic [31:0] pad;
        digest_beat_t d;
        if (!b.fin)
        begin
            absorb_word(b.word);
            msg_bits += 32;
            return;
        end
        v = (b.nbits > 32) ? 32 : b.nbits;
        msg_bits += v;
        if (v == 32)
        begin
            absorb_word(b.word);
            pad = 32'h8000_0000;
        end
        else
            pad = (b.word & ((v == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - v))))
                  | (32'h1 << (31 - v));
        absorb_word(pad);
        if (fill == 15)
        begin
            blk[15] = '0;
            compress();
            fill = 0;
        end
        for (int i = fill; i < 14; i++) blk[i] = '0;
        blk[14] = msg_bits[63:32];
        blk[15] = msg_bits[31:0];
        compress();
        for (int i = 0; i < 8; i++)
        begin
            d.word = chain[i];
            d.idx  = 3'(i);
            d.last = (i == 7);
            expected_digests.push_back(d);
        end
        for (int i = 0; i < 8; i++) chain[i] = sm3hbl_pkg::IV[i];
        fill = 0;
        msg_bits = '0;
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        $display("mismatch on %s: got %h want %h (digest beat %0d)", what, got, want,
                 digests_seen);
    endtask

    task automatic queue_message(input int nwords, input int last_bits);
        msg_beat_t b;
        for (int i = 0; i < nwords; i++)
        begin
            b.word  = $urandom;
            b.nbits = (i == nwords - 1) ? 6'(last_bits) : 6'(32);
            b.fin   = (i == nwords - 1);
            // short count on a non-final word must be ignored
            if (!b.fin && $urandom_range(0, 15) == 0) b.nbits = 6'($urandom_range(0, 63));
            pending_beats.push_back(b);
        end
    endtask

    // driver
    int in_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            msg_word   <= '0;
            valid_bits <= '0;
            final_word <= 1'b0;
            in_gap     = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_digest(pending_beats.pop_front());
                beats_sent++;
            end
            if (!(in_valid && in_stall))
            begin
                if (in_gap > 0)
                    in_gap--;
                else if (!quiet_phase && $urandom_range(0, 7) == 0)
                    in_gap = $urandom_range(1, 9);
                if (in_gap == 0 && pending_beats.size() > 0)
                begin
                    in_valid   <= 1'b1;
                    msg_word   <= pending_beats[0].word;
                    valid_bits <= pending_beats[0].nbits;
                    final_word <= pending_beats[0].fin;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and output stall
    int out_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap   = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_digests.size() == 0)
                begin
                    mismatches++;
                    $display("digest beat with nothing expected: %h", digest_word);
                end
                else
                begin
                    digest_beat_t e;
                    e = expected_digests.pop_front();
                    if (digest_word !== e.word) report("digest_word", digest_word, e.word);
                    if (word_index !== e.idx)
                        report("word_index", 32'(word_index), 32'(e.idx));
                    if (digest_last !== e.last)
                        report("digest_last", 32'(digest_last), 32'(e.last));
                end
                digests_seen++;
            end
            if (out_gap > 0)
                out_gap--;
            else if (!quiet_phase && $urandom_range(0, 7) == 0)
                out_gap = $urandom_range(1, 9);
            out_stall <= hold_off || (out_gap > 0);
        end
    end

    // long hold-off on the output so the core backs up
    initial
    begin
        hold_off = 1'b0;
        wait (beats_sent >= 30);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        mismatches  = 0;
        beats_sent  = 0;
        digests_seen = 0;
        quiet_phase = 1'b0;
        clk = 1'b0;
        for (int i = 0; i < 8; i++) chain[i] = sm3hbl_pkg::IV[i];
        for (int i = 0; i < 16; i++) blk[i] = '0;
        fill = 0;
        msg_bits = '0;
        rst_n = 1'b0;

        // directed: empty message, "abc", full words, masks, saturation, pad spills
        pending_beats.push_back(msg_beat_t'{32'h0, 6'd0, 1'b1});
        pending_beats.push_back(msg_beat_t'{32'h6162_63FF, 6'd24, 1'b1});
        pending_beats.push_back(msg_beat_t'{32'hFFFF_FFFF, 6'd32, 1'b1});
        pending_beats.push_back(msg_beat_t'{32'hFFFF_FFFF, 6'd1, 1'b1});
        pending_beats.push_back(msg_beat_t'{32'hFFFF_FFFF, 6'd31, 1'b1});
        pending_beats.push_back(msg_beat_t'{32'hA5A5_A5A5, 6'd63, 1'b1});
        pending_beats.push_back(msg_beat_t'{32'h1234_5678, 6'd40, 1'b1});
        queue_message(14, 32);
        queue_message(15, 32);
        queue_message(16, 0);

        repeat (3) @(posedge clk);
        rst_n = 1'b1;

        // random messages, mostly short, a few spanning several blocks
        while (pending_beats.size() < 130)
        begin
            if (pending_beats.size() < 100 && $urandom_range(0, 5) == 0)
                queue_message($urandom_range(14, 34), $urandom_range(0, 63));
            else
                queue_message($urandom_range(1, 6), $urandom_range(0, 33));
        end
        wait (pending_beats.size() < 20);
        quiet_phase = 1'b1;
        queue_message(3, 17);
        queue_message(1, 32);
        wait (pending_beats.size() == 0 && !in_valid);
        wait (expected_digests.size() == 0);
        repeat (200) @(posedge clk);
        $display("sent %0d message beats, checked %0d digest beats, %0d mismatches",
                 beats_sent, digests_seen, mismatches);
        if (mismatches == 0 && expected_digests.size() == 0)
            $display("tb_sm3_hash_bit_length OK");
        else
            $display("tb_sm3_hash_bit_length NOT OK");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout: %0d digest beats still expected", expected_digests.size());
        $display("tb_sm3_hash_bit_length NOT OK");
        $finish;
    end

endmodule
`default_nettype wire
